// File: sv/mcstb_pkg.sv
// Package for the timer bank: sizes, opcodes, table entry and sequencer types.
// Shared by the interfaces, the channel table, the step unit, the sequencer and the top level.
// No dependencies.
package mcstb_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int COUNT_WIDTH  = 16;

  localparam int OP_W     = 2;
  localparam int CHAN_W   = 5;
  localparam int PERIOD_W = 16;
  localparam int MASK_W   = 16;

  // Channel address width and a walk index wide enough to hold NUM_CHANNELS itself.
  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_IW = $clog2(NUM_CHANNELS + 1);

  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);
  localparam logic [32:0]     CNT_MAX_W = (33'd1 << COUNT_WIDTH) - 33'd1;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CH_AW-1:0]       ch_addr_t;
  typedef logic [CH_IW-1:0]       ch_idx_t;

  typedef struct packed {
    count_t period;
    count_t count;
  } chan_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } seq_state_t;

  typedef struct packed {
    logic     idle;
    logic     rd_en;
    ch_addr_t rd_addr;
    logic     proc_vld;
    ch_addr_t proc_idx;
    logic     done;
  } seq_ctrl_t;

  // A period beyond the count range is stored as the largest count.
  function automatic count_t sat_period(input logic [PERIOD_W-1:0] per);
    logic [32:0] wide;
    wide = 33'(per);
    if (wide > CNT_MAX_W) begin
      return '1;
    end else begin
      return count_t'(wide);
    end
  endfunction

endpackage

// File: sv/mcstb_in_if.sv
// Request channel of the timer bank: valid/ready handshake plus the request fields.
// Depends on mcstb_pkg for the field widths.
interface mcstb_in_if import mcstb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [CHAN_W-1:0]   channel;
  logic [PERIOD_W-1:0] period;
  logic                one_shot;
  logic                notify;

  modport source (output valid, opcode, channel, period, one_shot, notify, input ready);
  modport sink   (input valid, opcode, channel, period, one_shot, notify, output ready);
endinterface

// File: sv/mcstb_out_if.sv
// Result channel of the timer bank: valid/ready handshake plus status and expiry mask.
// Depends on mcstb_pkg for the field widths.
interface mcstb_out_if import mcstb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [MASK_W-1:0] expired_mask;

  modport source (output valid, status, expired_mask, input ready);
  modport sink   (input valid, status, expired_mask, output ready);
endinterface

// File: sv/multi_channel_soft_timer_bank_core.sv
// Timer bank with NUM_CHANNELS channels of COUNT_WIDTH-bit counts.
// Requests enter on in_req (opcode, channel, period, one_shot, notify) under valid/ready,
// and every request gives exactly one result on out_rsp (status, expired_mask).
// A start loads a channel's period and flags, clears its count and turns it on; it fails
// on a channel out of range or a zero period. A close turns a channel off and fails on a
// channel out of range. A tick advances every active channel; a channel reaching its
// period restarts, turns off if it is one-shot, and sets its mask bit if notify is on.
// Start and close finish in the cycle they are accepted; the registered result is valid in the next cycle.
// A tick walks the channel table through one shared incrementer and comparator, one channel
// per cycle behind a registered table read, and its result is loaded when the walk ends;
// the block takes no request during that walk.
// The result sits in an output register: a new request is taken while the previous result
// is being taken, and a stalled receiver holds the result and blocks further requests.
// Synchronous reset turns every channel off and empties the output register; the table
// contents are only used for channels that were started since, so they need no clearing.
// Depends on mcstb_pkg, mcstb_in_if, mcstb_out_if, mcstb_chan_ram, mcstb_step_unit, mcstb_seq.
module multi_channel_soft_timer_bank_core import mcstb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mcstb_in_if.sink    in_req,
  mcstb_out_if.source out_rsp
);

  seq_ctrl_t   ctrl;
  chan_entry_t rd_entry;
  chan_entry_t wr_entry;
  count_t      step_count;
  logic        step_hit;
  logic        ram_we;
  ch_addr_t    ram_waddr;

  logic              accept;
  logic              ch_ok;
  logic              per_ok;
  logic              is_start;
  logic              is_close;
  logic              is_tick;
  ch_addr_t          in_addr;
  logic              proc_live;

  logic [NUM_CHANNELS-1:0] active_r, active_nxt;
  logic [NUM_CHANNELS-1:0] once_r, once_nxt;
  logic [NUM_CHANNELS-1:0] notify_r, notify_nxt;
  logic [MASK_W-1:0]       mask_r, mask_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              status_r, status_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic              load_out;

  assign in_req.ready = ctrl.idle && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  assign is_start = (in_req.opcode == OP_START);
  assign is_close = (in_req.opcode == OP_CLOSE);
  assign is_tick  = (in_req.opcode == OP_TICK);
  assign ch_ok    = ({1'b0, in_req.channel} < CH_LIMIT);
  assign per_ok   = (in_req.period != '0);
  assign in_addr  = in_req.channel[CH_AW-1:0];

  mcstb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_start (accept && is_tick),
    .ctrl       (ctrl)
  );

  mcstb_chan_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ctrl.rd_en),
    .raddr (ctrl.rd_addr),
    .rdata (rd_entry)
  );

  mcstb_step_unit u_step (
    .entry      (rd_entry),
    .next_count (step_count),
    .hit        (step_hit)
  );

  assign proc_live = ctrl.proc_vld && active_r[ctrl.proc_idx];

  // Table writes: a start loads the entry, the tick walk writes back the stepped count.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = ctrl.proc_idx;
    wr_entry.period = rd_entry.period;
    wr_entry.count  = step_count;
    if (accept && is_start && ch_ok && per_ok) begin
      ram_we          = 1'b1;
      ram_waddr       = in_addr;
      wr_entry.period = sat_period(in_req.period);
      wr_entry.count  = '0;
    end else if (proc_live) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    active_nxt = active_r;
    once_nxt   = once_r;
    notify_nxt = notify_r;
    mask_nxt   = mask_r;
    if (accept && is_start && ch_ok && per_ok) begin
      active_nxt[in_addr] = 1'b1;
      once_nxt[in_addr]   = in_req.one_shot;
      notify_nxt[in_addr] = in_req.notify;
    end else if (accept && is_close && ch_ok) begin
      active_nxt[in_addr] = 1'b0;
    end
    if (accept && is_tick) begin
      mask_nxt = '0;
    end
    if (proc_live && step_hit) begin
      if (once_r[ctrl.proc_idx]) begin
        active_nxt[ctrl.proc_idx] = 1'b0;
      end
      // Only the low channels have a bit in the mask.
      for (int i = 0; i < MASK_W; i++) begin
        if (i < NUM_CHANNELS && int'(ctrl.proc_idx) == i && notify_r[ctrl.proc_idx]) begin
          mask_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    load_out     = 1'b0;
    status_nxt   = status_r;
    out_mask_nxt = out_mask_r;
    if (ctrl.done) begin
      load_out     = 1'b1;
      status_nxt   = 1'b0;
      out_mask_nxt = mask_nxt;
    end else if (accept && !is_tick) begin
      load_out     = 1'b1;
      out_mask_nxt = '0;
      if (is_start) begin
        status_nxt = !(ch_ok && per_ok);
      end else if (is_close) begin
        status_nxt = !ch_ok;
      end else begin
        status_nxt = 1'b1;
      end
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      once_r      <= '0;
      notify_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      once_r      <= once_nxt;
      notify_r    <= notify_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    status_r   <= status_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.expired_mask = out_mask_r;

endmodule

// File: sv/mcstb_chan_ram.sv
// Channel table: period and running count per channel, one write and one registered read port.
// Depends on mcstb_pkg for the entry type and address width.
module mcstb_chan_ram import mcstb_pkg::*; (
  input  logic        clk,
  input  logic        we,
  input  ch_addr_t    waddr,
  input  chan_entry_t wdata,
  input  logic        re,
  input  ch_addr_t    raddr,
  output chan_entry_t rdata
);

  chan_entry_t mem [NUM_CHANNELS];
  chan_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/mcstb_step_unit.sv
// Shared count step: advances one channel's count and checks it against the period.
// Depends on mcstb_pkg for the entry type.
module mcstb_step_unit import mcstb_pkg::*; (
  input  chan_entry_t entry,
  output count_t      next_count,
  output logic        hit
);

  count_t cnt_inc;

  assign cnt_inc    = entry.count + count_t'(1);
  assign hit        = (cnt_inc >= entry.period);
  assign next_count = hit ? '0 : cnt_inc;

endmodule

// File: sv/mcstb_seq.sv
// Sequencer for the tick walk: issues one table read per cycle and tracks the channel in process.
// Depends on mcstb_pkg for the state and control types.
module mcstb_seq import mcstb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tick_start,
  output seq_ctrl_t ctrl
);

  seq_state_t state_r, state_nxt;
  ch_idx_t    cnt_idx_r, cnt_idx_nxt;
  ch_addr_t   proc_idx_r, proc_idx_nxt;
  logic       proc_vld_r, proc_vld_nxt;
  logic       walk_end;

  assign walk_end = (cnt_idx_r == ch_idx_t'(NUM_CHANNELS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_start) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        if (walk_end && proc_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.idle     = 1'b0;
    ctrl.rd_en    = 1'b0;
    ctrl.rd_addr  = cnt_idx_r[CH_AW-1:0];
    ctrl.proc_vld = proc_vld_r;
    ctrl.proc_idx = proc_idx_r;
    ctrl.done     = 1'b0;
    case (state_r)
      ST_IDLE: ctrl.idle = 1'b1;
      ST_TICK: begin
        ctrl.rd_en = !walk_end;
        ctrl.done  = walk_end && proc_vld_r;
      end
      default: ctrl.idle = 1'b0;
    endcase
  end

  // The channel read in one cycle is processed in the next.
  always_comb begin
    cnt_idx_nxt  = cnt_idx_r;
    proc_vld_nxt = ctrl.rd_en;
    proc_idx_nxt = ctrl.rd_addr;
    if (state_r == ST_IDLE) begin
      cnt_idx_nxt = '0;
    end else if (ctrl.rd_en) begin
      cnt_idx_nxt = cnt_idx_r + ch_idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_idx_r  <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_idx_r  <= cnt_idx_nxt;
      proc_vld_r <= proc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
  end

endmodule
